// ----- rtl/psv_pkg.sv -----
// Package for the punctured soft Viterbi decoder: payload structs, codes, constants.
// No dependencies.
package psv_pkg;

    localparam logic       OP_SOFT   = 1'b0;
    localparam logic       OP_READ   = 1'b1;
    localparam logic       KIND_END  = 1'b0;
    localparam logic       KIND_BYTE = 1'b1;
    localparam logic [0:0] REG_PATTERN = 1'b0;
    localparam logic [0:0] REG_LENGTH  = 1'b1;
    localparam logic [15:0] ERASE_VAL   = 16'h7FFF;
    localparam logic [31:0] METRIC_SPAN = 32'h0001_FFFE;
    localparam logic [15:0] COST_A [8] = '{16'h0, 16'h0, 16'h0, 16'h0,
                                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    localparam logic [15:0] COST_B [8] = '{16'h0, 16'hFFFF, 16'hFFFF, 16'h0,
                                           16'h0, 16'hFFFF, 16'hFFFF, 16'h0};

    typedef struct packed {
        logic        op;
        logic [15:0] soft_value;
        logic        last;
        logic [7:0]  byte_index;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] frame_cost;
        logic [7:0]  decoded_byte;
        logic [10:0] step_total;
        logic        overflow;
    } out_word_t;

    // front -> back queue entry
    typedef struct packed {
        logic        is_read;   // byte read
        logic        is_start;  // new frame
        logic        is_end;    // traceback
        logic        has_pair;  // ACS pair valid
        logic [15:0] s0;
        logic [15:0] s1;
        logic [15:0] erasures;
        logic [7:0]  byte_index;
    } cmd_t;

endpackage

// ----- rtl/punctured_soft_viterbi_k5.sv -----
// Top level of the punctured soft-decision Viterbi decoder (K=5, rate 1/2).
// Depends on psv_pkg, psv_front, psv_queue, psv_back.
//
// channel   signals                          handshake
// input     start, busy, in_word             start && !busy
// config    cfg_valid, cfg_ready, cfg_*      cfg_valid && cfg_ready
// result    result_valid, result             one-cycle strobe
//
// Soft value: the front takes one pushed value (erasures included) per cycle
// while the queue has room; back does one ACS step per cycle while idle.
// Reset and frame start clear the byte store ((MaxSteps+11)/8 bytes). Traceback
// walks the survivors back step by step, then finds the minimum path metric.
// Reset is asynchronous; busy stays high until any result of the item is out;
// cfg_ready is low while busy. The receiver cannot stall.
module punctured_soft_viterbi_k5 #(
    parameter int MaxSteps = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  psv_pkg::in_word_t   in_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                result_valid,
    output psv_pkg::out_word_t  result
);

    logic          q_push, q_pop, q_empty, q_full, front_busy, back_busy;
    psv_pkg::cmd_t q_in, q_head;

    assign cfg_ready = !busy;
    assign busy = front_busy || !q_empty || back_busy;

    psv_front u_front (
        .clk, .rst_n, .start(start && !busy), .in_word,
        .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
        .q_full, .q_push, .q_data(q_in), .front_busy
    );

    psv_queue u_queue (
        .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
        .head(q_head), .empty(q_empty), .full(q_full)
    );

    psv_back #(.MaxSteps(MaxSteps)) u_back (
        .clk, .rst_n, .head(q_head), .empty(q_empty), .pop(q_pop),
        .back_busy, .done(result_valid), .result
    );

endmodule

// ----- rtl/psv_front.sv -----
// Front end: depuncturing, pairing, erasure counting; emits commands.
// Depends on psv_pkg.
module psv_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  psv_pkg::in_word_t  in_word,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               q_full,
    output logic               q_push,
    output psv_pkg::cmd_t      q_data,
    output logic               front_busy
);

    logic [63:0] pattern_reg;
    logic [6:0]  length_reg;
    logic [5:0]  ptr_reg, ptr_next;
    logic [15:0] pend_reg, pend_next;
    logic        pflag_reg, pflag_next;
    logic [15:0] erase_reg, erase_next;
    logic        open_reg, open_next;
    logic        act_reg, act_next;
    psv_pkg::in_word_t cur_reg, cur_next;
    logic        first_reg, first_next;

    logic [6:0]  len_eff;
    logic [63:0] mask;
    logic        any_set;
    logic [5:0]  ptr_fix, ptr_adv;
    logic        erase_now;
    logic [15:0] val;
    logic        push_d;
    psv_pkg::cmd_t cmd;

    always_comb
    begin
        len_eff = (length_reg == 7'd0) ? 7'd1 : ((length_reg > 7'd64) ? 7'd64 : length_reg);
        mask    = (len_eff == 7'd64) ? '1 : ((64'd1 << len_eff[5:0]) - 64'd1);
        any_set = |(pattern_reg & mask);
        ptr_fix = ({1'b0, ptr_reg} >= len_eff) ? 6'd0 : ptr_reg;
        ptr_adv = ({1'b0, ptr_fix} + 7'd1 >= len_eff) ? 6'd0 : ptr_fix + 6'd1;
        erase_now = any_set && !pattern_reg[ptr_fix];
        val = erase_now ? psv_pkg::ERASE_VAL : cur_reg.soft_value;
    end

    // one pushed value per cycle while the queue is not full; an item finishes when its real value is pushed
    always_comb
    begin
        ptr_next = ptr_reg; pend_next = pend_reg; pflag_next = pflag_reg;
        erase_next = erase_reg; open_next = open_reg; act_next = act_reg;
        cur_next = cur_reg; first_next = first_reg;
        push_d = 1'b0;
        cmd = '0;
        cmd.byte_index = cur_reg.byte_index;
        cmd.erasures = erase_reg;
        if (!act_reg)
        begin
            if (start)
            begin
                act_next = 1'b1;
                cur_next = in_word;
                first_next = (in_word.op == psv_pkg::OP_SOFT) && !open_reg;
            end
        end
        else if (!q_full)
        begin
            if (cur_reg.op == psv_pkg::OP_READ)
            begin
                cmd.is_read = 1'b1;
                push_d = 1'b1;
                act_next = 1'b0;
            end
            else if (first_reg)
            begin
                cmd.is_start = 1'b1;
                push_d = 1'b1;
                first_next = 1'b0;
                ptr_next = 6'd0; pend_next = '0; pflag_next = 1'b0;
                erase_next = '0; open_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_adv;
                if (erase_now && erase_reg != 16'hFFFF)
                    erase_next = erase_reg + 16'd1;
                if (!pflag_reg)
                begin
                    pend_next = val;
                    pflag_next = 1'b1;
                end
                else
                begin
                    pflag_next = 1'b0;
                    cmd.has_pair = 1'b1;
                    cmd.s0 = pend_reg;
                    cmd.s1 = val;
                    push_d = 1'b1;
                end
                if (!erase_now)
                begin
                    act_next = 1'b0;
                    if (cur_reg.last)
                    begin
                        cmd.is_end = 1'b1;
                        cmd.erasures = erase_next;
                        push_d = 1'b1;
                        pflag_next = 1'b0;
                        open_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '1; length_reg <= 7'd4;
            ptr_reg <= '0; pend_reg <= '0; pflag_reg <= 1'b0; erase_reg <= '0;
            open_reg <= 1'b0; act_reg <= 1'b0; first_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == psv_pkg::REG_PATTERN) pattern_reg <= cfg_data;
            if (cfg_we && cfg_index == psv_pkg::REG_LENGTH)  length_reg <= cfg_data[6:0];
            ptr_reg <= ptr_next; pend_reg <= pend_next; pflag_reg <= pflag_next;
            erase_reg <= erase_next; open_reg <= open_next; act_reg <= act_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign q_push = push_d;
    assign q_data = cmd;
    assign front_busy = act_reg;

    a_len: assert property (@(posedge clk) disable iff (!rst_n) len_eff >= 7'd1 && len_eff <= 7'd64)
        else $error("bad effective length");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n) {1'b0, ptr_adv} < len_eff)
        else $error("pointer past length");
    a_push: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full && act_reg)
        else $error("push without room");

endmodule

// ----- rtl/psv_queue.sv -----
// Small command FIFO between front and back.
// Depends on psv_pkg.
module psv_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psv_pkg::cmd_t push_data,
    input  logic          pop,
    output psv_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    psv_pkg::cmd_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg] <= push_data;
    end

    assign head  = mem[rp_reg];
    assign empty = (cnt_reg == 3'd0);
    assign full  = (cnt_reg == 3'd4);

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue overflow");
    a_unf: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count");

endmodule

// ----- rtl/psv_back.sv -----
// Back end: ACS, survivor memory, traceback, decoded byte store, results.
// Depends on psv_pkg.
module psv_back #(
    parameter int MaxSteps = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psv_pkg::cmd_t      head,
    input  logic               empty,
    output logic               pop,
    output logic               back_busy,
    output logic               done,
    output psv_pkg::out_word_t result
);

    localparam int SW = $clog2(MaxSteps);
    localparam int CW = $clog2(MaxSteps + 1);
    localparam int StoreBytes = (MaxSteps + 11) / 8;
    localparam int BW = $clog2(StoreBytes);
    localparam int PW = $clog2(MaxSteps + 5);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_TB_RD, S_TB, S_MIN, S_READ, S_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] pm_reg [16];
    logic [15:0] surv_mem [MaxSteps];
    logic [7:0]  dec_mem [StoreBytes];
    logic [CW-1:0] steps_reg;
    logic        ovf_reg;
    logic [CW-1:0] pos_reg;
    logic [7:0]  st_reg;
    logic [15:0] surv_q;
    logic [PW-1:0] bitpos_reg;
    logic [BW-1:0] addr_reg;
    logic [7:0]  byte_q;
    logic [4:0]  idx_reg;
    logic [31:0] best_reg;
    logic [15:0] erase_reg;
    logic        tb_we;
    logic [BW:0] clr_reg;
    psv_pkg::out_word_t res_reg;
    logic        done_reg;

    logic [31:0] pm_next [16];
    logic [15:0] surv_word;
    logic [16:0] bm [8];
    logic [31:0] m0, m1, m2, m3;

    always_comb
    begin
        surv_word = '0;
        for (int i = 0; i < 8; i++)
        begin
            bm[i] = {1'b0, (psv_pkg::COST_A[i] > head.s0) ? psv_pkg::COST_A[i] - head.s0
                                                           : head.s0 - psv_pkg::COST_A[i]}
                  + {1'b0, (psv_pkg::COST_B[i] > head.s1) ? psv_pkg::COST_B[i] - head.s1
                                                           : head.s1 - psv_pkg::COST_B[i]};
            m0 = pm_reg[i] + {15'd0, bm[i]};
            m1 = pm_reg[i+8] + (psv_pkg::METRIC_SPAN - {15'd0, bm[i]});
            m2 = pm_reg[i] + (psv_pkg::METRIC_SPAN - {15'd0, bm[i]});
            m3 = pm_reg[i+8] + {15'd0, bm[i]};
            surv_word[2*i]   = (m0 >= m1);
            pm_next[2*i]     = (m0 >= m1) ? m1 : m0;
            surv_word[2*i+1] = (m2 >= m3);
            pm_next[2*i+1]   = (m2 >= m3) ? m3 : m2;
        end
    end

    logic       tb_bit;
    logic [PW-1:0] bp_dec;
    logic [7:0] rd_sel;

    assign tb_bit = surv_q[st_reg[7:4]];
    assign bp_dec = bitpos_reg - PW'(1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && !empty && head.has_pair && steps_reg < CW'(MaxSteps))
            surv_mem[steps_reg[SW-1:0]] <= surv_word;
        surv_q <= surv_mem[pos_reg[SW-1:0] - SW'(1)];
        if (state_reg == S_CLEAR)
            dec_mem[clr_reg[BW-1:0]] <= 8'd0;
        else if (tb_we)
            dec_mem[addr_reg] <= byte_q | (8'h80 >> bitpos_reg[2:0]);
        byte_q <= dec_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            for (int i = 0; i < 16; i++) pm_reg[i] <= '0;
            steps_reg <= '0; ovf_reg <= 1'b0; pos_reg <= '0; st_reg <= '0;
            bitpos_reg <= '0; addr_reg <= '0; idx_reg <= '0; best_reg <= '0;
            erase_reg <= '0; tb_we <= 1'b0; clr_reg <= '0; res_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            tb_we <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        if (head.is_read)
                        begin
                            addr_reg <= BW'(head.byte_index);
                            res_reg.kind <= psv_pkg::KIND_BYTE;
                            res_reg.frame_cost <= '0;
                            res_reg.decoded_byte <= '0;
                            res_reg.step_total <= '0;
                            res_reg.overflow <= 1'b0;
                            if (int'(head.byte_index) < StoreBytes)
                                state_reg <= S_READ;
                            else
                                state_reg <= S_OUT;
                        end
                        else if (head.is_start)
                        begin
                            for (int i = 0; i < 16; i++) pm_reg[i] <= '0;
                            steps_reg <= '0; ovf_reg <= 1'b0; clr_reg <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            if (head.has_pair)
                            begin
                                if (steps_reg < CW'(MaxSteps))
                                begin
                                    for (int i = 0; i < 16; i++) pm_reg[i] <= pm_next[i];
                                    steps_reg <= steps_reg + CW'(1);
                                end
                                else
                                    ovf_reg <= 1'b1;
                            end
                            if (head.is_end)
                            begin
                                erase_reg <= head.erasures;
                                pos_reg <= (head.has_pair && steps_reg < CW'(MaxSteps))
                                           ? steps_reg + CW'(1) : steps_reg;
                                bitpos_reg <= PW'((head.has_pair && steps_reg < CW'(MaxSteps))
                                           ? steps_reg + CW'(1) : steps_reg) + PW'(4);
                                st_reg <= '0;
                                state_reg <= S_TB_RD;
                            end
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (BW+1)'(1);
                    if (clr_reg == (BW+1)'(StoreBytes - 1)) state_reg <= S_IDLE;
                end
                S_TB_RD:
                begin
                    // survivor word fetched for position pos-1; byte address set for bitpos-1
                    if (pos_reg == '0)
                    begin
                        idx_reg <= 5'd1; best_reg <= pm_reg[0];
                        state_reg <= S_MIN;
                    end
                    else
                    begin
                        addr_reg <= BW'(bp_dec >> 3);
                        state_reg <= S_TB;
                    end
                end
                S_TB:
                begin
                    if (!tb_we)
                    begin
                        // surv_q valid; byte_q for addr_reg is fetched here for the write
                        bitpos_reg <= bp_dec;
                        pos_reg <= pos_reg - CW'(1);
                        st_reg <= {tb_bit, st_reg[7:1]};
                        if (tb_bit) tb_we <= 1'b1;
                        else state_reg <= S_TB_RD;
                    end
                    else
                        state_reg <= S_TB_RD;
                end
                S_MIN:
                begin
                    if (pm_reg[idx_reg[3:0]] < best_reg) best_reg <= pm_reg[idx_reg[3:0]];
                    idx_reg <= idx_reg + 5'd1;
                    if (idx_reg == 5'd15)
                    begin
                        res_reg.kind <= psv_pkg::KIND_END;
                        res_reg.frame_cost <= ((pm_reg[15] < best_reg) ? pm_reg[15] : best_reg)
                            - ({16'd0, erase_reg} * 32'h7FFF);
                        res_reg.decoded_byte <= '0;
                        res_reg.step_total <= 11'(steps_reg);
                        res_reg.overflow <= ovf_reg;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    res_reg.decoded_byte <= rd_sel;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    logic rd_in_range;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rd_in_range <= 1'b0;
        else if (state_reg == S_IDLE) rd_in_range <= !empty && head.is_read
            && (int'(head.byte_index) < StoreBytes);
    end
    assign rd_sel = rd_in_range ? byte_q : 8'd0;

    assign pop = (state_reg == S_IDLE) && !empty;
    assign back_busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign result = res_reg;

    a_steps: assert property (@(posedge clk) disable iff (!rst_n) steps_reg <= CW'(MaxSteps))
        else $error("step count past limit");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= steps_reg)
        else $error("traceback past frame");
    a_done: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("double result");

endmodule
